@@ sv/dft_pkg.sv @@
// Shared types and constants for the dipole field line tracer.
// Used by dft_alu, dft_seq and dipole_field_line_tracer; no dependencies.
package dft_pkg;

  localparam int MAX_STEPS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic [2:0] REG_DIPOLE_X  = 3'd0;
  localparam logic [2:0] REG_DIPOLE_Y  = 3'd1;
  localparam logic [2:0] REG_AXIS_X    = 3'd2;
  localparam logic [2:0] REG_AXIS_Y    = 3'd3;
  localparam logic [2:0] REG_MOMENT    = 3'd4;
  localparam logic [2:0] REG_STEP_LEN  = 3'd5;

  // Shared unit operations
  localparam logic [1:0] ALU_MUL  = 2'd0;
  localparam logic [1:0] ALU_DIV  = 2'd1;
  localparam logic [1:0] ALU_SQRT = 2'd2;

  localparam logic [15:0] ONE_Q14  = 16'd16384;
  localparam logic [63:0] WEAK_K   = 64'd1000000000000;  // 1e6 * 1e6
  localparam logic [63:0] ONE_SQ   = 64'd268435456;      // 16384^2

  typedef struct packed {
    logic [1:0] op;
    logic       neg;     // subtract partial products (negative multiplier)
    logic [6:0] nbits;   // iterations: multiplier bits, dividend bits or root pairs
  } alu_ctl_t;

  typedef struct packed {
    logic signed [31:0] dipole_x;
    logic signed [31:0] dipole_y;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [31:0] moment;
    logic        [23:0] step_len;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               last;
    logic               weak_hit;
  } emit_t;

endpackage

@@ sv/dipole_field_line_tracer.sv @@
// Top level of the dipole field line tracer: configuration registers,
// result register, sequencer and shared unit. Depends on dft_pkg, dft_seq, dft_alu.
//
//   channel | handshake            | word
//   --------+----------------------+-------------------------------------------
//   cfg     | cfg_valid/cfg_ready  | cfg_index (register), cfg_data
//   in      | in_valid/in_ready    | start_x, start_y, step_count
//   out     | out_valid/out_ready  | point_x, point_y, last_point, weak_stop
//
// For each traced point, every multiply, divide and root of
// the field evaluation runs one bit (or one root digit pair) per cycle through
// the single shared unit, and the steps of a trace depend on each other.
// in_ready is high only between traces.
// Synchronous reset restores the register reset values and idles the sequencer.
// A stalled result holds the sequencer at that point until the word is taken.
module dipole_field_line_tracer #(
  parameter int MAX_STEPS = dft_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS = dft_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic [6:0]         step_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic               last_point,
  output logic               weak_stop
);

  dft_pkg::cfg_t     cfg;
  dft_pkg::emit_t    emit;
  dft_pkg::alu_ctl_t alu_ctl;
  logic              emit_valid;
  logic              emit_ready;
  logic              alu_start;
  logic              alu_done;
  logic [127:0]      alu_a;
  logic [63:0]       alu_b;
  logic [127:0]      alu_c;
  logic [127:0]      alu_res;

  // Configuration is always accepted and takes effect at once; the host must
  // write registers only between traces, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dipole_x <= '0;
      cfg.dipole_y <= '0;
      cfg.axis_x   <= 16'sd16384;
      cfg.axis_y   <= '0;
      cfg.moment   <= 32'sd65536;
      cfg.step_len <= 24'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        dft_pkg::REG_DIPOLE_X: cfg.dipole_x <= cfg_data;
        dft_pkg::REG_DIPOLE_Y: cfg.dipole_y <= cfg_data;
        dft_pkg::REG_AXIS_X:   cfg.axis_x   <= cfg_data[15:0];
        dft_pkg::REG_AXIS_Y:   cfg.axis_y   <= cfg_data[15:0];
        dft_pkg::REG_MOMENT:   cfg.moment   <= cfg_data;
        dft_pkg::REG_STEP_LEN: cfg.step_len <= cfg_data[23:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Result register: take a new point when empty or being drained.
  assign emit_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ready) begin
      out_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit_valid) begin
      point_x    <= emit.px;
      point_y    <= emit.py;
      last_point <= emit.last;
      weak_stop  <= emit.weak_hit;
    end
  end

  dft_seq #(
    .MAX_STEPS (MAX_STEPS),
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_x    (start_x),
    .start_y    (start_y),
    .step_count (step_count),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit       (emit),
    .alu_start  (alu_start),
    .alu_ctl    (alu_ctl),
    .alu_a      (alu_a),
    .alu_b      (alu_b),
    .alu_c      (alu_c),
    .alu_done   (alu_done),
    .alu_res    (alu_res)
  );

  dft_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .ctl   (alu_ctl),
    .a     (alu_a),
    .b     (alu_b),
    .c     (alu_c),
    .done  (alu_done),
    .res   (alu_res)
  );

endmodule

@@ sv/dft_alu.sv @@
// Shared bit-serial unit: multiply-accumulate, restoring divide, integer root.
// Depends on dft_pkg for the operation codes and control struct.
module dft_alu (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dft_pkg::alu_ctl_t ctl,
  input  logic [127:0]      a,
  input  logic [63:0]       b,
  input  logic [127:0]      c,
  output logic              done,
  output logic [127:0]      res
);

  logic         busy;
  logic [6:0]   cnt;
  logic [1:0]   op;
  logic         neg;
  logic [127:0] acc;
  logic [127:0] areg;
  logic [63:0]  breg;
  logic [65:0]  rem;

  logic [65:0]  div_try;
  logic [65:0]  sq_try;
  logic [65:0]  sq_trial;
  logic [6:0]   sq_shamt;

  assign div_try  = {rem[64:0], breg[63]};
  assign sq_try   = {rem[63:0], breg[63:62]};
  assign sq_trial = {acc[63:0], 2'b01};
  assign sq_shamt = 7'd64 - {ctl.nbits[5:0], 1'b0};
  assign res      = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ctl.nbits;
        op   <= ctl.op;
        neg  <= ctl.neg;
        areg <= a;
        rem  <= '0;
        case (ctl.op)
          dft_pkg::ALU_MUL: begin
            acc  <= c;
            breg <= b;
          end
          dft_pkg::ALU_DIV: begin
            acc  <= '0;
            breg <= b << (7'd64 - ctl.nbits);
          end
          default: begin
            acc  <= '0;
            breg <= b << sq_shamt;
          end
        endcase
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        case (op)
          dft_pkg::ALU_MUL: begin
            if (breg[0]) acc <= neg ? acc - areg : acc + areg;
            areg <= areg << 1;
            breg <= breg >> 1;
          end
          dft_pkg::ALU_DIV: begin
            // restoring step: shift in the next dividend bit
            if (div_try >= areg[65:0]) begin
              rem <= div_try - areg[65:0];
              acc <= {acc[126:0], 1'b1};
            end else begin
              rem <= div_try;
              acc <= {acc[126:0], 1'b0};
            end
            breg <= breg << 1;
          end
          dft_pkg::ALU_SQRT: begin
            if (sq_try >= sq_trial) begin
              rem <= sq_try - sq_trial;
              acc <= {acc[126:0], 1'b1};
            end else begin
              rem <= sq_try;
              acc <= {acc[126:0], 1'b0};
            end
            breg <= breg << 2;
          end
          default: begin
            busy <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

@@ sv/dft_seq.sv @@
// Step sequencer: walks one field line, issuing each operation to dft_alu.
// Depends on dft_pkg; drives the shared unit and hands points to the top level.
module dft_seq #(
  parameter int MAX_STEPS = dft_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS = dft_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dft_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic [6:0]         step_count,
  output logic               emit_valid,
  input  logic               emit_ready,
  output dft_pkg::emit_t     emit,
  output logic               alu_start,
  output dft_pkg::alu_ctl_t  alu_ctl,
  output logic [127:0]       alu_a,
  output logic [63:0]        alu_b,
  output logic [127:0]       alu_c,
  input  logic               alu_done,
  input  logic [127:0]       alu_res
);

  localparam int WSH = 2 * FRAC_BITS - 14;
  localparam logic [6:0] MAXN = 7'(MAX_STEPS);

  localparam logic [5:0] ST_IDLE = 6'd0;
  localparam logic [5:0] ST_SQX  = 6'd1;
  localparam logic [5:0] ST_SQY  = 6'd2;
  localparam logic [5:0] ST_RT   = 6'd3;
  localparam logic [5:0] ST_CHK  = 6'd4;
  localparam logic [5:0] ST_DOTX = 6'd5;
  localparam logic [5:0] ST_DOTY = 6'd6;
  localparam logic [5:0] ST_CDIV = 6'd7;
  localparam logic [5:0] ST_CSQ  = 6'd8;
  localparam logic [5:0] ST_SRT  = 6'd9;
  localparam logic [5:0] ST_UX   = 6'd10;
  localparam logic [5:0] ST_UY   = 6'd11;
  localparam logic [5:0] ST_EX1  = 6'd12;
  localparam logic [5:0] ST_EX2  = 6'd13;
  localparam logic [5:0] ST_EY1  = 6'd14;
  localparam logic [5:0] ST_EY2  = 6'd15;
  localparam logic [5:0] ST_GSQ  = 6'd16;
  localparam logic [5:0] ST_GRT  = 6'd17;
  localparam logic [5:0] ST_PM   = 6'd18;
  localparam logic [5:0] ST_PK   = 6'd19;
  localparam logic [5:0] ST_R2   = 6'd20;
  localparam logic [5:0] ST_R3   = 6'd21;
  localparam logic [5:0] ST_WCMP = 6'd22;
  localparam logic [5:0] ST_L1   = 6'd23;
  localparam logic [5:0] ST_L2   = 6'd24;
  localparam logic [5:0] ST_LRT  = 6'd25;
  localparam logic [5:0] ST_DX   = 6'd26;
  localparam logic [5:0] ST_DY   = 6'd27;
  localparam logic [5:0] ST_EMIT = 6'd28;
  localparam logic [5:0] ST_MX   = 6'd29;
  localparam logic [5:0] ST_MY   = 6'd30;

  logic [5:0]         state;
  logic               issued;
  logic signed [31:0] walk_x, walk_y;
  logic [6:0]         steps_left;
  logic               weak_hit;
  logic [32:0]        r;
  logic signed [15:0] c_q;
  logic [28:0]        csq;
  logic [14:0]        s;
  logic signed [17:0] ux, uy;
  logic signed [35:0] ex, ey;
  logic [15:0]        g;
  logic [127:0]       pw;
  logic [127:0]       tmp;
  logic [30:0]        len;
  logic signed [15:0] dxv, dyv;

  logic signed [32:0] ax, ay;
  logic [32:0]        mx, my;
  logic               sh;
  logic [31:0]        hx, hy;
  logic [16:0]        c2;
  logic [15:0]        cmag;
  logic [17:0]        abs_ux, abs_uy;
  logic [35:0]        abs_ex, abs_ey;
  logic [15:0]        abs_ax_x, abs_ax_y;
  logic [127:0]       abs_tmp;
  logic [31:0]        abs_m;
  logic [15:0]        abs_dx, abs_dy;
  logic               alu_st;
  logic [127:0]       wlhs;
  logic [24:0]        mstep;
  logic signed [33:0] wsum;
  logic signed [31:0] wsat;
  logic [15:0]        cq_mag;
  logic signed [15:0] c_new;

  assign ax = {walk_x[31], walk_x} - {cfg.dipole_x[31], cfg.dipole_x};
  assign ay = {walk_y[31], walk_y} - {cfg.dipole_y[31], cfg.dipole_y};
  assign mx = ax[32] ? 33'(-ax) : 33'(ax);
  assign my = ay[32] ? 33'(-ay) : 33'(ay);
  assign sh = mx[32] | mx[31] | my[32] | my[31];
  assign hx = sh ? mx[32:1] : mx[31:0];
  assign hy = sh ? my[32:1] : my[31:0];
  assign c2 = {c_q, 1'b0};
  assign cmag = c_q[15] ? 16'(-c_q) : 16'(c_q);
  assign abs_ux = ux[17] ? 18'(-ux) : 18'(ux);
  assign abs_uy = uy[17] ? 18'(-uy) : 18'(uy);
  assign abs_ex = ex[35] ? 36'(-ex) : 36'(ex);
  assign abs_ey = ey[35] ? 36'(-ey) : 36'(ey);
  assign abs_ax_x = cfg.axis_x[15] ? 16'(-cfg.axis_x) : 16'(cfg.axis_x);
  assign abs_ax_y = cfg.axis_y[15] ? 16'(-cfg.axis_y) : 16'(cfg.axis_y);
  assign abs_tmp = tmp[127] ? (128'd0 - tmp) : tmp;
  assign abs_m = cfg.moment[31] ? 32'(-cfg.moment) : 32'(cfg.moment);
  assign abs_dx = dxv[15] ? 16'(-dxv) : 16'(dxv);
  assign abs_dy = dyv[15] ? 16'(-dyv) : 16'(dyv);
  assign wlhs = pw << WSH;
  assign mstep = alu_res[38:14];
  assign cq_mag = (alu_res > 128'd16384) ? dft_pkg::ONE_Q14 : alu_res[15:0];
  assign c_new = tmp[127] ? 16'(-cq_mag) : 16'(cq_mag);

  // saturating walk update for the axis being moved
  always_comb begin
    if (state == ST_MX)
      wsum = dxv[15] ? {walk_x[31], walk_x[31], walk_x} - {9'd0, mstep}
                     : {walk_x[31], walk_x[31], walk_x} + {9'd0, mstep};
    else
      wsum = dyv[15] ? {walk_y[31], walk_y[31], walk_y} - {9'd0, mstep}
                     : {walk_y[31], walk_y[31], walk_y} + {9'd0, mstep};
    if (wsum > 34'sh0_7FFF_FFFF)
      wsat = 32'sh7FFF_FFFF;
    else if (wsum < -34'sh0_8000_0000)
      wsat = -32'sh8000_0000;
    else
      wsat = wsum[31:0];
  end

  // operand setup for the shared unit
  always_comb begin
    alu_st        = 1'b1;
    alu_ctl.op    = dft_pkg::ALU_MUL;
    alu_ctl.neg   = 1'b0;
    alu_ctl.nbits = 7'd32;
    alu_a         = '0;
    alu_b         = '0;
    alu_c         = '0;
    case (state)
      ST_SQX: begin
        alu_a = {96'd0, hx};
        alu_b = {32'd0, hx};
      end
      ST_SQY: begin
        alu_a = {96'd0, hy};
        alu_b = {32'd0, hy};
        alu_c = tmp;
      end
      ST_RT: begin
        alu_ctl.op = dft_pkg::ALU_SQRT;
        alu_b = tmp[63:0];
      end
      ST_DOTX: begin
        alu_a = {{95{ax[32]}}, ax};
        alu_b = {48'd0, abs_ax_x};
        alu_ctl.neg = cfg.axis_x[15];
        alu_ctl.nbits = 7'd16;
      end
      ST_DOTY: begin
        alu_a = {{95{ay[32]}}, ay};
        alu_b = {48'd0, abs_ax_y};
        alu_ctl.neg = cfg.axis_y[15];
        alu_ctl.nbits = 7'd16;
        alu_c = tmp;
      end
      ST_CDIV: begin
        alu_ctl.op = dft_pkg::ALU_DIV;
        alu_ctl.nbits = 7'd52;
        alu_a = {95'd0, r};
        alu_b = abs_tmp[63:0];
      end
      ST_CSQ: begin
        alu_a = {112'd0, cmag};
        alu_b = {48'd0, cmag};
        alu_ctl.nbits = 7'd15;
      end
      ST_SRT: begin
        alu_ctl.op = dft_pkg::ALU_SQRT;
        alu_ctl.nbits = 7'd15;
        alu_b = dft_pkg::ONE_SQ - {35'd0, csq};
      end
      ST_UX: begin
        alu_ctl.op = dft_pkg::ALU_DIV;
        alu_ctl.nbits = 7'd48;
        alu_a = {95'd0, r};
        alu_b = {17'd0, mx, 14'd0};
      end
      ST_UY: begin
        alu_ctl.op = dft_pkg::ALU_DIV;
        alu_ctl.nbits = 7'd48;
        alu_a = {95'd0, r};
        alu_b = {17'd0, my, 14'd0};
      end
      ST_EX1: begin
        alu_a = {{111{c2[16]}}, c2};
        alu_b = {46'd0, abs_ux};
        alu_ctl.neg = ux[17];
        alu_ctl.nbits = 7'd18;
      end
      ST_EX2: begin
        alu_a = {113'd0, s};
        alu_b = {46'd0, abs_uy};
        alu_ctl.neg = uy[17];
        alu_ctl.nbits = 7'd18;
        alu_c = tmp;
      end
      ST_EY1: begin
        alu_a = {{111{c2[16]}}, c2};
        alu_b = {46'd0, abs_uy};
        alu_ctl.neg = uy[17];
        alu_ctl.nbits = 7'd18;
      end
      ST_EY2: begin
        alu_a = {113'd0, s};
        alu_b = {46'd0, abs_ux};
        alu_ctl.neg = !ux[17];
        alu_ctl.nbits = 7'd18;
        alu_c = tmp;
      end
      ST_GSQ: begin
        alu_a = {113'd0, s};
        alu_b = {49'd0, s};
        alu_ctl.nbits = 7'd15;
        alu_c = {97'd0, csq, 2'b00};
      end
      ST_GRT: begin
        alu_ctl.op = dft_pkg::ALU_SQRT;
        alu_ctl.nbits = 7'd16;
        alu_b = tmp[63:0];
      end
      ST_PM: begin
        alu_a = {96'd0, abs_m};
        alu_b = {48'd0, g};
        alu_ctl.nbits = 7'd16;
      end
      ST_PK: begin
        alu_a = tmp;
        alu_b = dft_pkg::WEAK_K;
        alu_ctl.nbits = 7'd40;
      end
      ST_R2: begin
        alu_a = {95'd0, r};
        alu_b = {31'd0, r};
        alu_ctl.nbits = 7'd33;
      end
      ST_R3: begin
        alu_a = tmp;
        alu_b = {31'd0, r};
        alu_ctl.nbits = 7'd33;
      end
      ST_L1: begin
        alu_a = {96'd0, abs_ex[31:0]};
        alu_b = {32'd0, abs_ex[31:0]};
      end
      ST_L2: begin
        alu_a = {96'd0, abs_ey[31:0]};
        alu_b = {32'd0, abs_ey[31:0]};
        alu_c = tmp;
      end
      ST_LRT: begin
        alu_ctl.op = dft_pkg::ALU_SQRT;
        alu_ctl.nbits = 7'd31;
        alu_b = tmp[63:0];
      end
      ST_DX: begin
        alu_ctl.op = dft_pkg::ALU_DIV;
        alu_ctl.nbits = 7'd46;
        alu_a = {97'd0, len};
        alu_b = {14'd0, abs_ex, 14'd0};
      end
      ST_DY: begin
        alu_ctl.op = dft_pkg::ALU_DIV;
        alu_ctl.nbits = 7'd46;
        alu_a = {97'd0, len};
        alu_b = {14'd0, abs_ey, 14'd0};
      end
      ST_MX: begin
        alu_a = {104'd0, cfg.step_len};
        alu_b = {48'd0, abs_dx};
        alu_ctl.nbits = 7'd15;
      end
      ST_MY: begin
        alu_a = {104'd0, cfg.step_len};
        alu_b = {48'd0, abs_dy};
        alu_ctl.nbits = 7'd15;
      end
      default: alu_st = 1'b0;
    endcase
  end

  assign alu_start     = alu_st && !issued;
  assign in_ready      = (state == ST_IDLE);
  assign emit_valid    = (state == ST_EMIT);
  assign emit.px       = walk_x;
  assign emit.py       = walk_y;
  assign emit.weak_hit = weak_hit;
  assign emit.last     = weak_hit || (steps_left == 7'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      issued     <= 1'b0;
      walk_x     <= '0;
      walk_y     <= '0;
      steps_left <= '0;
      weak_hit   <= 1'b0;
    end else begin
      if (alu_start) issued <= 1'b1;
      if (alu_done) begin
        issued <= 1'b0;
        tmp    <= alu_res;
      end
      case (state)
        ST_IDLE: begin
          weak_hit <= 1'b0;
          if (in_valid) begin
            walk_x     <= start_x;
            walk_y     <= start_y;
            steps_left <= (step_count > MAXN) ? MAXN : step_count;
            if (step_count != 7'd0) state <= ST_SQX;
          end
        end
        ST_CHK: begin
          if (r == 33'd0 || cfg.moment == 32'sd0) begin
            weak_hit <= 1'b1;
            state    <= ST_EMIT;
          end else begin
            state <= ST_DOTX;
          end
        end
        ST_WCMP: begin
          if (wlhs < tmp) begin
            weak_hit <= 1'b1;
            state    <= ST_EMIT;
          end else begin
            state <= ST_L1;
          end
        end
        ST_EMIT: begin
          if (emit_ready) begin
            steps_left <= steps_left - 7'd1;
            if (emit.last) state <= ST_IDLE;
            else state <= ST_MX;
          end
        end
        default: begin
          if (alu_done) begin
            state <= state + 6'd1;
            case (state)
              ST_RT:   r <= sh ? {alu_res[31:0], 1'b0} : {1'b0, alu_res[31:0]};
              ST_CDIV: c_q <= c_new;
              ST_CSQ:  csq <= alu_res[28:0];
              ST_SRT:  s <= alu_res[14:0];
              ST_UX:   ux <= ax[32] ? 18'(-alu_res[17:0]) : alu_res[17:0];
              ST_UY:   uy <= ay[32] ? 18'(-alu_res[17:0]) : alu_res[17:0];
              ST_EX2:  ex <= alu_res[35:0];
              ST_EY2: begin
                // flip the field for a negative moment
                if (cfg.moment[31]) begin
                  ex <= -ex;
                  ey <= 36'(-alu_res[35:0]);
                end else begin
                  ey <= alu_res[35:0];
                end
              end
              ST_GRT:  g <= alu_res[15:0];
              ST_PK:   pw <= alu_res;
              ST_LRT: begin
                len <= alu_res[30:0];
                if (alu_res[30:0] == 31'd0) begin
                  weak_hit <= 1'b1;
                  state    <= ST_EMIT;
                end
              end
              ST_DX:   dxv <= ex[35] ? 16'(-alu_res[15:0]) : alu_res[15:0];
              ST_DY:   dyv <= ey[35] ? 16'(-alu_res[15:0]) : alu_res[15:0];
              ST_MX:   walk_x <= wsat;
              ST_MY: begin
                walk_y <= wsat;
                state  <= ST_SQX;
              end
              default: ;
            endcase
          end
        end
      endcase
    end
  end

endmodule
